@@ src/bpfg_pkg.sv @@
package bpfg_pkg;

    localparam int ROW_WIDTH    = 64;
    localparam int FRAME_HEIGHT = 64;

    localparam int COL_W = $clog2(ROW_WIDTH);
    localparam int ROW_W = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;

    localparam int PROB_W  = 16;
    localparam int PICK_W  = 2;
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 6;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USED_COLOR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_COLOR      = 2'd2;

    localparam logic [PROB_W-1:0]  THRESHOLD_RESET   = 16'd3277;
    localparam logic [COLOR_W-1:0] USED_COLOR_RESET  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] EMPTY_COLOR_RESET = 24'h000000;

    localparam logic [PICK_W-1:0] PICK_RIGHT = 2'd2;
    localparam logic [PICK_W-1:0] PICK_OVER  = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             top;
        logic             last;
        logic             branch;
        logic [PICK_W-1:0] pick;
    } bpfg_cmd_t;

    typedef struct packed {
        logic [PROB_W-1:0]  branch_threshold;
        logic [COLOR_W-1:0] used_color;
        logic [COLOR_W-1:0] empty_color;
    } bpfg_cfg_t;

    function automatic logic [INDEX_W-1:0] row_field(input logic [ROW_W-1:0] r);
        logic [ROW_W+INDEX_W-1:0] t;
        t = (ROW_W + INDEX_W)'(r);
        return t[INDEX_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] col_field(input logic [COL_W-1:0] c);
        logic [COL_W+INDEX_W-1:0] t;
        t = (COL_W + INDEX_W)'(c);
        return t[INDEX_W-1:0];
    endfunction

endpackage

@@ src/bpfg_front.sv @@
module bpfg_front
    import bpfg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [PROB_W-1:0] rand_prob,
    input  logic [PICK_W-1:0] rand_pick,
    input  logic [PROB_W-1:0] branch_threshold,
    output bpfg_cmd_t         cmd
);

    logic [ROW_W-1:0] scan_row_reg;
    logic [ROW_W-1:0] scan_row_next;
    logic [COL_W-1:0] scan_col_reg;
    logic [COL_W-1:0] scan_col_next;
    logic             row_end;
    logic             top;

    assign row_end = (scan_col_reg == COL_W'(ROW_WIDTH - 1));
    assign top     = (scan_row_reg == '0);

    always_comb
    begin
        cmd.row    = scan_row_reg;
        cmd.col    = scan_col_reg;
        cmd.top    = top;
        cmd.last   = row_end && top;
        cmd.branch = (rand_prob < branch_threshold);
        cmd.pick   = rand_pick;
    end

    always_comb
    begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg + 1'b1;
        if (row_end)
        begin
            scan_col_next = '0;
            scan_row_next = top ? ROW_W'(FRAME_HEIGHT - 1) : scan_row_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg <= ROW_W'(FRAME_HEIGHT - 1);
            scan_col_reg <= '0;
        end
        else if (accept)
        begin
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
        end
    end

endmodule

@@ src/bpfg_queue.sv @@
module bpfg_queue
    import bpfg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bpfg_cmd_t push_data,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output bpfg_cmd_t pop_data
);

    bpfg_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

endmodule

@@ src/bpfg_back.sv @@
module bpfg_back
    import bpfg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  bpfg_cmd_t          cmd,
    output logic               cmd_pop,
    input  logic [COLOR_W-1:0] used_color,
    input  logic [COLOR_W-1:0] empty_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COLOR_W-1:0] pixel_color,
    output logic [INDEX_W-1:0] row_index,
    output logic [INDEX_W-1:0] col_index,
    output logic               frame_last
);

    logic [ROW_WIDTH-1:0] cur_lit_reg;
    logic [ROW_WIDTH-1:0] cur_lit_next;
    logic [ROW_WIDTH-1:0] up_lit_reg;
    logic [ROW_WIDTH-1:0] up_lit_next;
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   pixel_color_reg;
    logic [INDEX_W-1:0]   row_index_reg;
    logic [INDEX_W-1:0]   col_index_reg;
    logic                 frame_last_reg;

    logic                 lit;
    logic                 at_left;
    logic                 at_right;
    logic [1:0]           offset;
    logic [2:0]           base;
    logic [ROW_WIDTH+1:0] spread;
    logic [ROW_WIDTH-1:0] light_mask;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        lit      = cur_lit_reg[cmd.col];
        at_left  = (cmd.col == '0);
        at_right = (cmd.col == COL_W'(ROW_WIDTH - 1));
        if (at_left)
        begin
            offset = {1'b0, cmd.pick[0]} + 2'd1;
        end
        else if (at_right)
        begin
            offset = {1'b0, cmd.pick[0]};
        end
        else if (cmd.pick == PICK_OVER)
        begin
            offset = PICK_RIGHT;
        end
        else
        begin
            offset = cmd.pick;
        end
        base       = (cmd.branch && !at_left && !at_right) ? 3'b101 : (3'b001 << offset);
        spread     = (ROW_WIDTH + 2)'(base) << cmd.col;
        light_mask = (lit && !cmd.top) ? spread[ROW_WIDTH:1] : '0;
    end

    always_comb
    begin
        cur_lit_next = cur_lit_reg;
        up_lit_next  = up_lit_reg | light_mask;
        if (at_right)
        begin
            up_lit_next  = '0;
            cur_lit_next = cmd.top ? '1 : (up_lit_reg | light_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_lit_reg   <= '1;
            up_lit_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                cur_lit_reg   <= cur_lit_next;
                up_lit_reg    <= up_lit_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            pixel_color_reg <= lit ? used_color : empty_color;
            row_index_reg   <= row_field(cmd.row);
            col_index_reg   <= col_field(cmd.col);
            frame_last_reg  <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;
    assign row_index   = row_index_reg;
    assign col_index   = col_index_reg;
    assign frame_last  = frame_last_reg;

endmodule

@@ src/branching_plasma_frame_generator_core.sv @@
// Channel | Handshake                 | Payload
// in      | in_valid / in_ready       | rand_prob, rand_pick
// out     | out_valid / out_ready     | pixel_color, row_index, col_index, frame_last
// cfg     | cfg_we (no wait)          | cfg_index, cfg_wdata
//
// One transfer in and one transfer out per cycle when both sides flow.
// The front classifies each input into a two-entry queue, and the back
// resolves lit bits and loads the output register.
// Reset starts a new frame at the bottom row and loads the register defaults.
// in_ready drops only when the queue is full, i.e. after out_ready has stalled.
module branching_plasma_frame_generator_core
    import bpfg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PROB_W-1:0]    rand_prob,
    input  logic [PICK_W-1:0]    rand_pick,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic [INDEX_W-1:0]   row_index,
    output logic [INDEX_W-1:0]   col_index,
    output logic                 frame_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    bpfg_cfg_t cfg_reg;
    bpfg_cmd_t front_cmd;
    bpfg_cmd_t queue_cmd;
    logic      accept;
    logic      queue_full;
    logic      queue_valid;
    logic      queue_pop;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.branch_threshold <= THRESHOLD_RESET;
            cfg_reg.used_color       <= USED_COLOR_RESET;
            cfg_reg.empty_color      <= EMPTY_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BRANCH_THRESHOLD: cfg_reg.branch_threshold <= cfg_wdata[PROB_W-1:0];
                CFG_USED_COLOR:       cfg_reg.used_color       <= cfg_wdata[COLOR_W-1:0];
                CFG_EMPTY_COLOR:      cfg_reg.empty_color      <= cfg_wdata[COLOR_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    bpfg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .rand_prob        (rand_prob),
        .rand_pick        (rand_pick),
        .branch_threshold (cfg_reg.branch_threshold),
        .cmd              (front_cmd)
    );

    bpfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_cmd),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .pop_data  (queue_cmd)
    );

    bpfg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (queue_valid),
        .cmd         (queue_cmd),
        .cmd_pop     (queue_pop),
        .used_color  (cfg_reg.used_color),
        .empty_color (cfg_reg.empty_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .row_index   (row_index),
        .col_index   (col_index),
        .frame_last  (frame_last)
    );

endmodule
